/* rtl/ufbs_pkg.sv */
// Package for the fractional UART baud divider search.
// Holds widths, limits, status codes, register indexes, the control state type and the divider structs.
// No dependencies; every other file in rtl uses it by scoped names.
package ufbs_pkg;

  // field widths
  localparam int unsigned PCLK_W  = 28;
  localparam int unsigned BAUD_W  = 24;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned DL_W    = 17;
  localparam int unsigned MUL_W   = 4;
  localparam int unsigned STAT_W  = 2;

  // search limits
  localparam int unsigned MUL_MAX     = 15;
  localparam int unsigned DIVISOR_MAX = 65536;
  localparam int unsigned PCT_SAT     = 100;

  // serial divider: 60-bit dividend, 29-bit divisor, one quotient bit a cycle
  localparam int unsigned DVD_W     = 60;
  localparam int unsigned DVS_W     = 29;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned FRAC_W    = 32;
  localparam int unsigned WHOLE_W   = DVD_W - FRAC_W;

  localparam logic [FRAC_W-1:0] FRAC_HALF = 32'h8000_0000;
  localparam logic [FRAC_W-1:0] ERR_INIT  = 32'hFFFF_FFFF;

  // register reset values
  localparam logic [PCLK_W-1:0] PCLK_RESET  = 28'd25000000;
  localparam logic [PCT_W-1:0]  LIMIT_RESET = 7'd3;

  // register indexes
  localparam logic CFG_PCLK  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_ACCEPT   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_DIV   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ERR_HIGH = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_PAIR     = 8'b0000_0010,
    S_PAIR_WT  = 8'b0000_0100,
    S_EVAL     = 8'b0000_1000,
    S_ACH      = 8'b0001_0000,
    S_ACH_WT   = 8'b0010_0000,
    S_PCT      = 8'b0100_0000,
    S_PCT_WT   = 8'b1000_0000
  } state_t;

  // request from the sequencer to the serial divider
  typedef struct packed {
    logic             load;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // status and quotient back from the serial divider
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/uart_fractional_baud_search_unit.sv */
// Top level of the fractional UART baud divider search.
// Depends on ufbs_pkg and ufbs_div (the shared bit-serial divider).
//
// Usage:
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready is always high.
//   Index CFG_PCLK writes the peripheral clock in Hz, CFG_LIMIT the accepted
//   error percent. Write only while busy is low.
//   Request: pulse start with in_baud_rate while busy is low; the transaction
//   is taken on that edge and busy rises the next cycle unless in_baud_rate is zero.
//   Result: out_strobe is high for one cycle with status, divisor latch,
//   multiplier, add value and percent error. The receiver cannot stall; busy
//   is already low in the strobe cycle, so a new start may follow at once.
// Sequence:
//   Each (mul, add) candidate takes a divider load, the divider steps, a done
//   pulse and an evaluation. A full search covers 120 candidates plus the
//   achieved-baud and percent divisions; an exact divisor ends the search
//   early. A zero baud answers in the cycle after start. Search time is set
//   mainly by the one-bit-per-cycle divider, which is shared by all three
//   divisions.
// Reset: rst_n is synchronous; it returns the sequencer to idle and restores
// the register reset values (25 MHz clock, 3 percent limit).
module uart_fractional_baud_search_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ufbs_pkg::BAUD_W-1:0]   in_baud_rate,
  output logic                          out_strobe,
  output logic [ufbs_pkg::STAT_W-1:0]   out_status,
  output logic [ufbs_pkg::DL_W-1:0]     out_divisor_latch,
  output logic [ufbs_pkg::MUL_W-1:0]    out_mul_val,
  output logic [ufbs_pkg::MUL_W-1:0]    out_divadd_val,
  output logic [ufbs_pkg::PCT_W-1:0]    out_error_percent,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [ufbs_pkg::PCLK_W-1:0]   cfg_data
);

  ufbs_pkg::state_t state_r, state_nxt;

  logic [ufbs_pkg::PCLK_W-1:0]  pclk_r;
  logic [ufbs_pkg::PCT_W-1:0]   limit_r;
  logic [ufbs_pkg::BAUD_W-1:0]  baud_r;
  logic [ufbs_pkg::MUL_W-1:0]   m_r;
  logic [ufbs_pkg::MUL_W-1:0]   d_r;
  logic [ufbs_pkg::FRAC_W-1:0]  best_err_r;
  logic [ufbs_pkg::DL_W-1:0]    best_div_r;
  logic [ufbs_pkg::MUL_W-1:0]   best_m_r;
  logic [ufbs_pkg::MUL_W-1:0]   best_d_r;
  logic [ufbs_pkg::PCLK_W-1:0]  diff_r;

  logic                         out_strobe_r;
  logic [ufbs_pkg::STAT_W-1:0]  out_status_r;
  logic [ufbs_pkg::DL_W-1:0]    out_div_r;
  logic [ufbs_pkg::MUL_W-1:0]   out_m_r;
  logic [ufbs_pkg::MUL_W-1:0]   out_d_r;
  logic [ufbs_pkg::PCT_W-1:0]   out_pct_r;

  ufbs_pkg::div_req_t div_req;
  ufbs_pkg::div_rsp_t div_rsp;

  logic                           accept;
  logic [ufbs_pkg::FRAC_W-1:0]    frac;
  logic [ufbs_pkg::WHOLE_W-1:0]   whole;
  logic                           round_up;
  logic [ufbs_pkg::FRAC_W-1:0]    frac_adj;
  logic [ufbs_pkg::WHOLE_W:0]     whole_adj;
  logic                           in_range;
  logic                           better;
  logic                           hit_zero;
  logic                           last_pair;
  logic                           found;
  logic [ufbs_pkg::PCLK_W-1:0]    achieved;
  logic [ufbs_pkg::PCLK_W-1:0]    baud_ext;
  logic [ufbs_pkg::PCT_W-1:0]     pct_sat;
  logic [ufbs_pkg::MUL_W:0]       m_plus_d;
  logic [ufbs_pkg::MUL_W:0]       best_m_plus_d;

  assign accept    = start && (state_r == ufbs_pkg::S_IDLE);
  assign busy      = (state_r != ufbs_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pclk_r  <= ufbs_pkg::PCLK_RESET;
      limit_r <= ufbs_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ufbs_pkg::CFG_PCLK:  pclk_r  <= cfg_data;
        ufbs_pkg::CFG_LIMIT: limit_r <= cfg_data[ufbs_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // round the candidate quotient to the nearest divisor, exact half rounds down
  always_comb begin
    frac      = div_rsp.quotient[ufbs_pkg::FRAC_W-1:0];
    whole     = div_rsp.quotient[ufbs_pkg::DVD_W-1:ufbs_pkg::FRAC_W];
    round_up  = (frac > ufbs_pkg::FRAC_HALF);
    frac_adj  = round_up ? (ufbs_pkg::FRAC_W'(0) - frac) : frac;
    whole_adj = {1'b0, whole} + (ufbs_pkg::WHOLE_W+1)'(round_up);
    in_range  = (whole_adj != '0) &&
                (whole_adj <= (ufbs_pkg::WHOLE_W+1)'(ufbs_pkg::DIVISOR_MAX));
    better    = in_range && (frac_adj < best_err_r);
    hit_zero  = better && (frac_adj == '0);
    last_pair = (m_r == ufbs_pkg::MUL_W'(ufbs_pkg::MUL_MAX)) && (d_r == m_r - 1'b1);
    found     = better || (best_div_r != '0);
  end

  // achieved baud difference and saturated percent
  always_comb begin
    achieved = div_rsp.quotient[ufbs_pkg::PCLK_W-1:0];
    baud_ext = ufbs_pkg::PCLK_W'(baud_r);
    if ((|div_rsp.quotient[ufbs_pkg::DVD_W-1:ufbs_pkg::PCT_W]) ||
        (div_rsp.quotient[ufbs_pkg::PCT_W-1:0] > ufbs_pkg::PCT_W'(ufbs_pkg::PCT_SAT))) begin
      pct_sat = ufbs_pkg::PCT_W'(ufbs_pkg::PCT_SAT);
    end else begin
      pct_sat = div_rsp.quotient[ufbs_pkg::PCT_W-1:0];
    end
  end

  assign m_plus_d      = {1'b0, m_r} + {1'b0, d_r};
  assign best_m_plus_d = {1'b0, best_m_r} + {1'b0, best_d_r};

  // divider request: candidate, achieved baud, or percent error
  always_comb begin
    div_req.load     = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      ufbs_pkg::S_PAIR: begin
        div_req.load     = 1'b1;
        div_req.dividend = {(32)'(pclk_r) * 32'(m_r), 28'd0};
        div_req.divisor  = ufbs_pkg::DVS_W'(baud_r) * ufbs_pkg::DVS_W'(m_plus_d);
      end
      ufbs_pkg::S_ACH: begin
        div_req.load     = 1'b1;
        div_req.dividend = ufbs_pkg::DVD_W'(ufbs_pkg::PCLK_W'(pclk_r[ufbs_pkg::PCLK_W-1:4]) *
                                            ufbs_pkg::PCLK_W'(best_m_r));
        div_req.divisor  = ufbs_pkg::DVS_W'(22'(best_div_r) * 22'(best_m_plus_d));
      end
      ufbs_pkg::S_PCT: begin
        div_req.load     = 1'b1;
        div_req.dividend = ufbs_pkg::DVD_W'(35'(diff_r) * 35'd100);
        div_req.divisor  = ufbs_pkg::DVS_W'(baud_r);
      end
      default: ;
    endcase
  end

  ufbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ufbs_pkg::S_IDLE:
        if (accept && (in_baud_rate != '0)) state_nxt = ufbs_pkg::S_PAIR;
      ufbs_pkg::S_PAIR:    state_nxt = ufbs_pkg::S_PAIR_WT;
      ufbs_pkg::S_PAIR_WT: if (div_rsp.done) state_nxt = ufbs_pkg::S_EVAL;
      ufbs_pkg::S_EVAL: begin
        if (hit_zero || last_pair) begin
          state_nxt = found ? ufbs_pkg::S_ACH : ufbs_pkg::S_IDLE;
        end else begin
          state_nxt = ufbs_pkg::S_PAIR;
        end
      end
      ufbs_pkg::S_ACH:     state_nxt = ufbs_pkg::S_ACH_WT;
      ufbs_pkg::S_ACH_WT:  if (div_rsp.done) state_nxt = ufbs_pkg::S_PCT;
      ufbs_pkg::S_PCT:     state_nxt = ufbs_pkg::S_PCT_WT;
      ufbs_pkg::S_PCT_WT:  if (div_rsp.done) state_nxt = ufbs_pkg::S_IDLE;
      default:             state_nxt = ufbs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufbs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // search bookkeeping: capture request, walk pairs, track the best one
  always_ff @(posedge clk) begin
    if (accept) begin
      baud_r     <= in_baud_rate;
      m_r        <= ufbs_pkg::MUL_W'(1);
      d_r        <= '0;
      best_err_r <= ufbs_pkg::ERR_INIT;
      best_div_r <= '0;
      best_m_r   <= '0;
      best_d_r   <= '0;
    end else if (state_r == ufbs_pkg::S_EVAL) begin
      if (better) begin
        best_err_r <= frac_adj;
        best_div_r <= whole_adj[ufbs_pkg::DL_W-1:0];
        best_m_r   <= m_r;
        best_d_r   <= d_r;
      end
      if (d_r == m_r - 1'b1) begin
        m_r <= m_r + 1'b1;
        d_r <= '0;
      end else begin
        d_r <= d_r + 1'b1;
      end
    end
    if ((state_r == ufbs_pkg::S_ACH_WT) && div_rsp.done) begin
      diff_r <= (baud_ext > achieved) ? (baud_ext - achieved) : (achieved - baud_ext);
    end
  end

  // result strobe: control part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (accept && (in_baud_rate == '0)) ||
                      ((state_r == ufbs_pkg::S_EVAL) && (hit_zero || last_pair) && !found) ||
                      ((state_r == ufbs_pkg::S_PCT_WT) && div_rsp.done);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state_r == ufbs_pkg::S_PCT_WT) && div_rsp.done) begin
      out_status_r <= (pct_sat < limit_r) ? ufbs_pkg::STAT_ACCEPT : ufbs_pkg::STAT_ERR_HIGH;
      out_div_r    <= best_div_r;
      out_m_r      <= best_m_r;
      out_d_r      <= best_d_r;
      out_pct_r    <= pct_sat;
    end else if (accept || (state_r == ufbs_pkg::S_EVAL)) begin
      out_status_r <= ufbs_pkg::STAT_NO_DIV;
      out_div_r    <= '0;
      out_m_r      <= '0;
      out_d_r      <= '0;
      out_pct_r    <= '0;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_divisor_latch = out_div_r;
  assign out_mul_val       = out_m_r;
  assign out_divadd_val    = out_d_r;
  assign out_error_percent = out_pct_r;

  // a result leaves only once the sequencer is back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while search still running");

  // a no-divisor result carries no pair
  a_nodiv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ufbs_pkg::STAT_NO_DIV)) |->
      ((out_divisor_latch == '0) && (out_mul_val == '0) && (out_divadd_val == '0)))
    else $error("no-divisor result with nonzero pair");

  // the pair walk stays in the legal triangle
  a_pair_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ufbs_pkg::S_EVAL) |-> ((m_r != '0) && (d_r < m_r)))
    else $error("candidate pair out of range");

  // the divider is never reloaded mid-division
  a_div_reload: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.load |-> !div_rsp.busy)
    else $error("divider loaded while busy");

  // a reported pair (any status but no-divisor) always has add value below multiplier
  a_result_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ufbs_pkg::STAT_NO_DIV)) |->
      ((out_divadd_val < out_mul_val) && (out_divisor_latch != '0)))
    else $error("reported pair inconsistent");

endmodule

/* rtl/ufbs_div.sv */
// Restoring radix-2 divider: one quotient bit per cycle.
// Depends on ufbs_pkg for widths and the request/response structs.
// Divisor must be nonzero; the quotient holds until the next load.
module ufbs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ufbs_pkg::div_req_t req,
  output ufbs_pkg::div_rsp_t rsp
);

  logic [ufbs_pkg::DVD_W-1:0] quo_r;
  logic [ufbs_pkg::DVS_W-1:0] rem_r;
  logic [ufbs_pkg::DVS_W-1:0] dvs_r;
  logic [ufbs_pkg::CNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [ufbs_pkg::DVS_W:0]   shifted;
  logic [ufbs_pkg::DVS_W:0]   trial;
  logic                       fits;
  logic [ufbs_pkg::DVS_W-1:0] rem_nxt;

  // trial subtract of the divisor from the partial remainder
  always_comb begin
    shifted = {rem_r, quo_r[ufbs_pkg::DVD_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
    rem_nxt = fits ? trial[ufbs_pkg::DVS_W-1:0] : shifted[ufbs_pkg::DVS_W-1:0];
  end

  // control: count steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == ufbs_pkg::CNT_W'(ufbs_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // datapath: shift dividend out the top, quotient bits in the bottom
  always_ff @(posedge clk) begin
    if (req.load) begin
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[ufbs_pkg::DVD_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
